// ----- design/prlt_pkg.sv -----
// ---------------------------------------------------------------------------
// prlt_pkg: shared definitions for the per-client rate limit table
// Table sizes, divider reciprocals, result codes and the command and status
// groups between the controller and the datapath.
// ---------------------------------------------------------------------------
package prlt_pkg;

	// table geometry
	localparam int TABLE_ENTRIES    = 1024;
	localparam int PROBE_LIMIT      = 24;
	localparam int WINDOW_SLOTS     = 10;
	localparam int SECONDS_PER_TICK = 6;

	localparam int ENTRY_W    = $clog2(TABLE_ENTRIES);
	localparam int SLOT_DEPTH = TABLE_ENTRIES * WINDOW_SLOTS;
	localparam int SLOT_W     = $clog2(SLOT_DEPTH);
	localparam int REM_W      = $clog2(WINDOW_SLOTS);
	localparam int CNT_W      = (SLOT_W > 7) ? SLOT_W : 7;

	// field widths
	localparam int ADDR_W   = 64;
	localparam int TIME_W   = 32;
	localparam int LIMIT_W  = 16;
	localparam int ACTION_W = 2;
	localparam int SUM_W    = 20;
	localparam int TICK_W   = 30;
	localparam int COUNT_W  = 16;
	localparam int HASH_W   = 32;

	localparam int ENTRY_DW = 2 * ADDR_W + TIME_W;
	localparam int SLOT_DW  = TICK_W + COUNT_W;

	localparam logic [HASH_W-1:0]  HASH_SEED = 32'd5381;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
	localparam int HASH_BYTES = 2 * ADDR_W / 8;

	// constant division by multiply with a ceiling reciprocal, exact for 32-bit inputs
	localparam int DIV_SH  = 38;
	localparam int RECIP_W = 39;
	localparam logic [63:0] TICK_RECIP64 =
		((64'd1 << DIV_SH) + 64'(SECONDS_PER_TICK) - 64'd1) / 64'(SECONDS_PER_TICK);
	localparam logic [63:0] SLOT_RECIP64 =
		((64'd1 << DIV_SH) + 64'(WINDOW_SLOTS) - 64'd1) / 64'(WINDOW_SLOTS);
	localparam logic [RECIP_W-1:0] TICK_RECIP = TICK_RECIP64[RECIP_W-1:0];
	localparam logic [RECIP_W-1:0] SLOT_RECIP = SLOT_RECIP64[RECIP_W-1:0];

	// result codes
	localparam logic [ACTION_W-1:0] ACT_CONTINUE = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_DROP     = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_TEMPFAIL = 2'd2;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_HASH,
		OP_PRB_RD,
		OP_PRB_CK,
		OP_VICT,
		OP_UPD_RD,
		OP_UPD_WR,
		OP_SUM_RD,
		OP_SUM_ACC,
		OP_ENT_WR,
		OP_RESULT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic cnt_clr;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic hash_last;
		logic probe_last;
		logic slot_last;
		logic match;
		logic bypass;
		logic out_free;
	} sts_t;

endpackage

// ----- design/prlt_ctrl.sv -----
// ---------------------------------------------------------------------------
// prlt_ctrl: request sequencer
// Sweeps the memories after reset, then steps a request through hash, probe,
// slot update, window sum and write back by issuing datapath operations.
// ---------------------------------------------------------------------------
module prlt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  prlt_pkg::sts_t sts,
	output prlt_pkg::cmd_t cmd,
	output logic           in_stall
);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_PRB_RD,
		ST_PRB_CK,
		ST_VICT,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_SUM_RD,
		ST_SUM_ACC,
		ST_ENT_WR,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state and operation
	always_comb begin
		state_d     = state_q;
		cmd.op      = prlt_pkg::OP_NONE;
		cmd.cnt_clr = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.op = prlt_pkg::OP_CLEAR;
				if (sts.clear_last) begin
					cmd.cnt_clr = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op      = prlt_pkg::OP_LOAD;
					cmd.cnt_clr = 1'b1;
					state_d     = ST_HASH;
				end
			end
			ST_HASH: begin
				cmd.op = prlt_pkg::OP_HASH;
				if (sts.bypass) begin
					state_d = ST_FINISH;
				end else if (sts.hash_last) begin
					cmd.cnt_clr = 1'b1;
					state_d     = ST_PRB_RD;
				end
			end
			ST_PRB_RD: begin
				cmd.op  = prlt_pkg::OP_PRB_RD;
				state_d = ST_PRB_CK;
			end
			ST_PRB_CK: begin
				cmd.op = prlt_pkg::OP_PRB_CK;
				if (sts.match) begin
					cmd.cnt_clr = 1'b1;
					state_d     = ST_UPD_RD;
				end else if (sts.probe_last) begin
					cmd.cnt_clr = 1'b1;
					state_d     = ST_VICT;
				end else begin
					state_d = ST_PRB_RD;
				end
			end
			ST_VICT: begin
				cmd.op = prlt_pkg::OP_VICT;
				if (sts.slot_last) begin
					cmd.cnt_clr = 1'b1;
					state_d     = ST_UPD_RD;
				end
			end
			ST_UPD_RD: begin
				cmd.op  = prlt_pkg::OP_UPD_RD;
				state_d = ST_UPD_WR;
			end
			ST_UPD_WR: begin
				cmd.op      = prlt_pkg::OP_UPD_WR;
				cmd.cnt_clr = 1'b1;
				state_d     = ST_SUM_RD;
			end
			ST_SUM_RD: begin
				cmd.op  = prlt_pkg::OP_SUM_RD;
				state_d = ST_SUM_ACC;
			end
			ST_SUM_ACC: begin
				cmd.op = prlt_pkg::OP_SUM_ACC;
				if (sts.slot_last) begin
					cmd.cnt_clr = 1'b1;
					state_d     = ST_ENT_WR;
				end else begin
					state_d = ST_SUM_RD;
				end
			end
			ST_ENT_WR: begin
				cmd.op  = prlt_pkg::OP_ENT_WR;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.op  = prlt_pkg::OP_RESULT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

// ----- design/prlt_dpath.sv -----
// ---------------------------------------------------------------------------
// prlt_dpath: rate limit datapath
// Request registers, hash, tick dividers, entry and slot memories, window
// accumulator, configuration register and the result register.
// ---------------------------------------------------------------------------
module prlt_dpath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  prlt_pkg::cmd_t                       cmd,
	output prlt_pkg::sts_t                       sts,
	input  logic [prlt_pkg::ADDR_W-1:0]          address_high,
	input  logic [prlt_pkg::ADDR_W-1:0]          address_low,
	input  logic [prlt_pkg::TIME_W-1:0]          now_seconds,
	input  logic [prlt_pkg::LIMIT_W-1:0]         conn_limit,
	input  logic                                 cfg_we,
	input  logic                                 cfg_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [prlt_pkg::ACTION_W-1:0]        action,
	output logic [prlt_pkg::SUM_W-1:0]           window_count,
	output logic                                 entry_replaced
);

	logic [prlt_pkg::ADDR_W-1:0]    ah_q, al_q;
	logic [prlt_pkg::TIME_W-1:0]    now_q;
	logic [prlt_pkg::LIMIT_W-1:0]   limit_q;
	logic [2*prlt_pkg::ADDR_W-1:0]  hbuf_q;
	logic [prlt_pkg::HASH_W-1:0]    hash_q;
	logic [prlt_pkg::CNT_W-1:0]     cnt_q;
	logic                           drop_q;

	logic [prlt_pkg::TIME_W+prlt_pkg::RECIP_W-1:0] prod_s1, prod_s2;
	logic [prlt_pkg::TIME_W-1:0]    ticks_s1, ticks_s2, quot_s2;
	logic [prlt_pkg::TIME_W-1:0]    rem_full;
	logic [prlt_pkg::REM_W-1:0]     rem_s3;
	logic [prlt_pkg::TICK_W-1:0]    tick30;

	logic [prlt_pkg::ENTRY_W-1:0]   home, probe_e, entry_q, oldest_q;
	logic [prlt_pkg::TIME_W-1:0]    oldest_t_q;
	logic                           found_q;
	logic [prlt_pkg::SLOT_W-1:0]    base;

	logic [prlt_pkg::ENTRY_DW-1:0]  ent_mem [prlt_pkg::TABLE_ENTRIES];
	logic [prlt_pkg::ENTRY_DW-1:0]  ent_rd_q, ent_wdata;
	logic [prlt_pkg::ENTRY_W-1:0]   ent_addr;
	logic                           ent_we, ent_re;

	logic [prlt_pkg::SLOT_DW-1:0]   slot_mem [prlt_pkg::SLOT_DEPTH];
	logic [prlt_pkg::SLOT_DW-1:0]   slot_rd_q, slot_wdata;
	logic [prlt_pkg::SLOT_W-1:0]    slot_addr;
	logic                           slot_we, slot_re;

	logic [prlt_pkg::TIME_W-1:0]    touched;
	logic                           older;
	logic [prlt_pkg::TICK_W-1:0]    rd_tick, age;
	logic [prlt_pkg::COUNT_W-1:0]   rd_count, upd_base, upd_count;
	logic [prlt_pkg::SUM_W:0]       sum_wide;
	logic [prlt_pkg::SUM_W-1:0]     sum_q;
	logic                           clear_ent;

	// request registers and hash shifter
	always_ff @(posedge clk) begin
		if (cmd.op == prlt_pkg::OP_LOAD) begin
			ah_q    <= address_high;
			al_q    <= address_low;
			now_q   <= now_seconds;
			limit_q <= conn_limit;
			hbuf_q  <= {address_high, address_low};
			hash_q  <= prlt_pkg::HASH_SEED;
		end else if (cmd.op == prlt_pkg::OP_HASH) begin
			hash_q <= ((hash_q << 5) + hash_q)
				^ {{(prlt_pkg::HASH_W-8){1'b0}}, hbuf_q[2*prlt_pkg::ADDR_W-1 -: 8]};
			hbuf_q <= hbuf_q << 8;
		end
	end

	// tick and slot number, registered in prod_s1, then prod_s2 and ticks_s2, then rem_s3
	assign ticks_s1 = prod_s1[prlt_pkg::DIV_SH +: prlt_pkg::TIME_W];
	assign quot_s2  = prod_s2[prlt_pkg::DIV_SH +: prlt_pkg::TIME_W];
	assign rem_full = ticks_s2 - prlt_pkg::TIME_W'(quot_s2 * prlt_pkg::TIME_W'(prlt_pkg::WINDOW_SLOTS));
	assign tick30   = ticks_s2[prlt_pkg::TICK_W-1:0];

	always_ff @(posedge clk) begin
		prod_s1  <= (prlt_pkg::TIME_W+prlt_pkg::RECIP_W)'(now_q)
			* (prlt_pkg::TIME_W+prlt_pkg::RECIP_W)'(prlt_pkg::TICK_RECIP);
		prod_s2  <= (prlt_pkg::TIME_W+prlt_pkg::RECIP_W)'(ticks_s1)
			* (prlt_pkg::TIME_W+prlt_pkg::RECIP_W)'(prlt_pkg::SLOT_RECIP);
		ticks_s2 <= ticks_s1;
		rem_s3   <= rem_full[prlt_pkg::REM_W-1:0];
	end

	// step counter shared by the clear, hash, probe, victim and sum phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.op == prlt_pkg::OP_CLEAR || cmd.op == prlt_pkg::OP_HASH
				|| cmd.op == prlt_pkg::OP_PRB_CK || cmd.op == prlt_pkg::OP_VICT
				|| cmd.op == prlt_pkg::OP_SUM_ACC) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// probe bookkeeping
	assign home    = hash_q[prlt_pkg::ENTRY_W-1:0];
	assign probe_e = home + cnt_q[prlt_pkg::ENTRY_W-1:0];
	assign touched = ent_rd_q[prlt_pkg::TIME_W-1:0];
	assign older   = (cnt_q == '0) || (touched < oldest_t_q);

	always_ff @(posedge clk) begin
		if (cmd.op == prlt_pkg::OP_PRB_CK) begin
			if (older) begin
				oldest_q   <= probe_e;
				oldest_t_q <= touched;
			end
			entry_q <= (sts.match || older) ? probe_e : oldest_q;
			found_q <= sts.match;
		end
	end

	assign base = prlt_pkg::SLOT_W'(prlt_pkg::SLOT_W'(entry_q)
		* prlt_pkg::SLOT_W'(prlt_pkg::WINDOW_SLOTS));

	// entry memory port
	assign clear_ent = (cnt_q < prlt_pkg::CNT_W'(prlt_pkg::TABLE_ENTRIES));
	always_comb begin
		ent_addr  = probe_e;
		ent_wdata = {ah_q, al_q, now_q};
		ent_we    = 1'b0;
		ent_re    = 1'b0;
		case (cmd.op)
			prlt_pkg::OP_CLEAR: begin
				ent_addr  = cnt_q[prlt_pkg::ENTRY_W-1:0];
				ent_wdata = '0;
				ent_we    = clear_ent;
			end
			prlt_pkg::OP_PRB_RD: begin
				ent_re = 1'b1;
			end
			prlt_pkg::OP_ENT_WR: begin
				ent_addr = entry_q;
				ent_we   = 1'b1;
			end
			default: begin
				ent_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_addr] <= ent_wdata;
		end
		if (ent_re) begin
			ent_rd_q <= ent_mem[ent_addr];
		end
	end

	// slot update value
	assign rd_tick   = slot_rd_q[prlt_pkg::SLOT_DW-1 -: prlt_pkg::TICK_W];
	assign rd_count  = slot_rd_q[prlt_pkg::COUNT_W-1:0];
	assign upd_base  = (rd_tick != tick30) ? '0 : rd_count;
	assign upd_count = (upd_base == prlt_pkg::COUNT_MAX) ? upd_base : upd_base + 1'b1;

	// slot memory port
	always_comb begin
		slot_addr  = base + prlt_pkg::SLOT_W'(cnt_q);
		slot_wdata = '0;
		slot_we    = 1'b0;
		slot_re    = 1'b0;
		case (cmd.op)
			prlt_pkg::OP_CLEAR: begin
				slot_addr = cnt_q[prlt_pkg::SLOT_W-1:0];
				slot_we   = 1'b1;
			end
			prlt_pkg::OP_VICT: begin
				slot_we = 1'b1;
			end
			prlt_pkg::OP_UPD_RD: begin
				slot_addr = base + prlt_pkg::SLOT_W'(rem_s3);
				slot_re   = 1'b1;
			end
			prlt_pkg::OP_UPD_WR: begin
				slot_addr  = base + prlt_pkg::SLOT_W'(rem_s3);
				slot_wdata = {tick30, upd_count};
				slot_we    = 1'b1;
			end
			prlt_pkg::OP_SUM_RD: begin
				slot_re = 1'b1;
			end
			default: begin
				slot_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_addr] <= slot_wdata;
		end
		if (slot_re) begin
			slot_rd_q <= slot_mem[slot_addr];
		end
	end

	// window accumulator, saturating
	assign age      = tick30 - rd_tick;
	assign sum_wide = {1'b0, sum_q} + (prlt_pkg::SUM_W+1)'(rd_count);

	always_ff @(posedge clk) begin
		if (cmd.op == prlt_pkg::OP_LOAD) begin
			sum_q <= '0;
		end else if (cmd.op == prlt_pkg::OP_SUM_ACC
				&& age < prlt_pkg::TICK_W'(prlt_pkg::WINDOW_SLOTS)) begin
			sum_q <= sum_wide[prlt_pkg::SUM_W] ? prlt_pkg::SUM_MAX : sum_wide[prlt_pkg::SUM_W-1:0];
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_q <= 1'b1;
		end else if (cfg_we) begin
			drop_q <= cfg_data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.op == prlt_pkg::OP_RESULT) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == prlt_pkg::OP_RESULT) begin
			if (limit_q == '0) begin
				action         <= prlt_pkg::ACT_CONTINUE;
				window_count   <= '0;
				entry_replaced <= 1'b0;
			end else begin
				if (sum_q > prlt_pkg::SUM_W'(limit_q)) begin
					action <= drop_q ? prlt_pkg::ACT_DROP : prlt_pkg::ACT_TEMPFAIL;
				end else begin
					action <= prlt_pkg::ACT_CONTINUE;
				end
				window_count   <= sum_q;
				entry_replaced <= !found_q;
			end
		end
	end

	// status to the controller
	assign sts.clear_last = (cnt_q == prlt_pkg::CNT_W'(prlt_pkg::SLOT_DEPTH - 1));
	assign sts.hash_last  = (cnt_q == prlt_pkg::CNT_W'(prlt_pkg::HASH_BYTES - 1));
	assign sts.probe_last = (cnt_q == prlt_pkg::CNT_W'(prlt_pkg::PROBE_LIMIT - 1));
	assign sts.slot_last  = (cnt_q == prlt_pkg::CNT_W'(prlt_pkg::WINDOW_SLOTS - 1));
	assign sts.match      = (ent_rd_q[prlt_pkg::ENTRY_DW-1 -: prlt_pkg::ADDR_W] == ah_q)
		&& (ent_rd_q[prlt_pkg::TIME_W +: prlt_pkg::ADDR_W] == al_q);
	assign sts.bypass     = (limit_q == '0);
	assign sts.out_free   = !out_valid || !out_stall;

	// checks
	a_result_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == prlt_pkg::OP_RESULT |-> (!out_valid || !out_stall))
		else $error("result loaded over a waiting result");

	a_match_found: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == prlt_pkg::OP_PRB_CK && sts.match) |=> (found_q && entry_q == $past(probe_e)))
		else $error("probe hit not recorded");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= prlt_pkg::CNT_W'(prlt_pkg::SLOT_DEPTH - 1))
		else $error("step counter out of range");

	a_action_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && action != prlt_pkg::ACT_CONTINUE) |-> window_count != '0)
		else $error("reject with empty window");

endmodule

// ----- design/per_client_rate_limit_table.sv -----
// ---------------------------------------------------------------------------
// per_client_rate_limit_table: per-client connection rate limiter
// Hashes the client address into a linearly probed table, keeps per-tick
// connection counts and rejects clients over their per-minute limit.
// ---------------------------------------------------------------------------
//   channel   handshake            payload
//   in        in_valid / in_stall  address_high, address_low, now_seconds, conn_limit
//   out       out_valid / out_stall  action, window_count, entry_replaced
//   cfg       cfg_valid / cfg_ready  cfg_data (drop_on_exceed)
//
// A request with a nonzero limit is hashed over its 16 address bytes, probes up
// to 24 entries with a read and a check each, clears the 10 victim slots on a
// miss, updates its tick slot, sums the 10 window slots and writes back its entry.
// After reset the memories are swept, one slot per cycle, over all 10240 slots
// before the first request is taken; configuration writes are always taken.
// A result waits in an output register, so the next request is taken while
// out_stall holds it.
// ---------------------------------------------------------------------------
module per_client_rate_limit_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [prlt_pkg::ADDR_W-1:0]    address_high,
	input  logic [prlt_pkg::ADDR_W-1:0]    address_low,
	input  logic [prlt_pkg::TIME_W-1:0]    now_seconds,
	input  logic [prlt_pkg::LIMIT_W-1:0]   conn_limit,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [prlt_pkg::ACTION_W-1:0]  action,
	output logic [prlt_pkg::SUM_W-1:0]     window_count,
	output logic                           entry_replaced,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_data
);

	prlt_pkg::cmd_t cmd;
	prlt_pkg::sts_t sts;

	// register write always accepted
	assign cfg_ready = 1'b1;

	prlt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	prlt_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.address_high   (address_high),
		.address_low    (address_low),
		.now_seconds    (now_seconds),
		.conn_limit     (conn_limit),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.action         (action),
		.window_count   (window_count),
		.entry_replaced (entry_replaced)
	);

endmodule

// ----- dv/prlt_checker.sv -----
// ---------------------------------------------------------------------------
// prlt_checker: result predictor and scoreboard for the rate limit table
// Watches the request, result and configuration channels, keeps its own copy
// of the client table and window slots, and compares every result in order.
// ---------------------------------------------------------------------------
module prlt_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [prlt_pkg::ADDR_W-1:0]   address_high,
	input  logic [prlt_pkg::ADDR_W-1:0]   address_low,
	input  logic [prlt_pkg::TIME_W-1:0]   now_seconds,
	input  logic [prlt_pkg::LIMIT_W-1:0]  conn_limit,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [prlt_pkg::ACTION_W-1:0] action,
	input  logic [prlt_pkg::SUM_W-1:0]    window_count,
	input  logic                          entry_replaced,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic                          cfg_data,
	output int                            errors,
	output int                            pending,
	output int                            n_rejects,
	output int                            n_replaced
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [prlt_pkg::ACTION_W-1:0] act;
		logic [prlt_pkg::SUM_W-1:0]    cnt;
		logic                          repl;
	} verdict_t;

	bit [prlt_pkg::ADDR_W-1:0]  tab_hi [prlt_pkg::TABLE_ENTRIES];
	bit [prlt_pkg::ADDR_W-1:0]  tab_lo [prlt_pkg::TABLE_ENTRIES];
	bit [prlt_pkg::TIME_W-1:0]  tab_seen [prlt_pkg::TABLE_ENTRIES];
	bit [prlt_pkg::TICK_W-1:0]  slot_tk [prlt_pkg::SLOT_DEPTH];
	bit [prlt_pkg::COUNT_W-1:0] slot_ct [prlt_pkg::SLOT_DEPTH];
	bit                         drop_mode;
	verdict_t                   verdicts_q [$];

	// djb xor hash over the eight bytes of one word, most significant first
	function automatic bit [prlt_pkg::HASH_W-1:0] djb_word(bit [prlt_pkg::HASH_W-1:0] h,
			bit [prlt_pkg::ADDR_W-1:0] w);
		for (int k = 56; k >= 0; k -= 8)
			h = (h * 33) ^ prlt_pkg::HASH_W'(w[k+:8]);
		return h;
	endfunction

	// one connection: find or take an entry, bump the tick slot, sum the window
	function automatic verdict_t rate_verdict(bit [prlt_pkg::ADDR_W-1:0] ah,
			bit [prlt_pkg::ADDR_W-1:0] al, bit [prlt_pkg::TIME_W-1:0] now,
			bit [prlt_pkg::LIMIT_W-1:0] lim);
		verdict_t v;
		bit [prlt_pkg::ENTRY_W-1:0] home, oldest, e, ent;
		bit found;
		bit [prlt_pkg::TIME_W-1:0] ticks;
		bit [prlt_pkg::TICK_W-1:0] t30;
		int base, sl, sum;
		v.act = prlt_pkg::ACT_CONTINUE;
		v.cnt = '0;
		v.repl = 1'b0;
		if (lim == 0)
			return v;
		home = prlt_pkg::ENTRY_W'(djb_word(djb_word(prlt_pkg::HASH_SEED, ah), al));
		oldest = home;
		found = 1'b0;
		ent = '0;
		for (int i = 0; i < prlt_pkg::PROBE_LIMIT; i++) begin
			e = home + prlt_pkg::ENTRY_W'(i);
			if (tab_seen[e] < tab_seen[oldest])
				oldest = e;
			if (tab_hi[e] == ah && tab_lo[e] == al) begin
				ent = e;
				found = 1'b1;
				break;
			end
		end
		if (!found) begin
			ent = oldest;
			for (int s = 0; s < prlt_pkg::WINDOW_SLOTS; s++) begin
				slot_tk[int'(ent) * prlt_pkg::WINDOW_SLOTS + s] = '0;
				slot_ct[int'(ent) * prlt_pkg::WINDOW_SLOTS + s] = '0;
			end
			tab_hi[ent] = ah;
			tab_lo[ent] = al;
		end
		ticks = now / prlt_pkg::SECONDS_PER_TICK;
		t30 = ticks[prlt_pkg::TICK_W-1:0];
		base = int'(ent) * prlt_pkg::WINDOW_SLOTS;
		sl = base + int'(ticks % prlt_pkg::WINDOW_SLOTS);
		if (slot_tk[sl] != t30) begin
			slot_tk[sl] = t30;
			slot_ct[sl] = '0;
		end
		if (slot_ct[sl] != prlt_pkg::COUNT_MAX)
			slot_ct[sl]++;
		sum = 0;
		for (int s = 0; s < prlt_pkg::WINDOW_SLOTS; s++)
			if (prlt_pkg::TICK_W'(t30 - slot_tk[base + s]) < prlt_pkg::WINDOW_SLOTS)
				sum += slot_ct[base + s];
		if (sum > int'(prlt_pkg::SUM_MAX))
			sum = int'(prlt_pkg::SUM_MAX);
		tab_seen[ent] = now;
		if (sum > int'(lim))
			v.act = drop_mode ? prlt_pkg::ACT_DROP : prlt_pkg::ACT_TEMPFAIL;
		v.cnt = prlt_pkg::SUM_W'(sum);
		v.repl = !found;
		return v;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	// result check first, then configuration, then the new request
	always @(posedge clk or negedge arst_n) begin
		verdict_t v;
		if (!arst_n) begin
			for (int i = 0; i < prlt_pkg::TABLE_ENTRIES; i++) begin
				tab_hi[i] = '0;
				tab_lo[i] = '0;
				tab_seen[i] = '0;
			end
			for (int i = 0; i < prlt_pkg::SLOT_DEPTH; i++) begin
				slot_tk[i] = '0;
				slot_ct[i] = '0;
			end
			drop_mode = 1'b1;
			verdicts_q.delete();
			errors = 0;
			pending = 0;
			n_rejects = 0;
			n_replaced = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (verdicts_q.size() == 0) begin
					report_mismatch("results outstanding", 1, 0);
				end else begin
					v = verdicts_q.pop_front();
					if (action !== v.act)
						report_mismatch("action", action, v.act);
					if (window_count !== v.cnt)
						report_mismatch("window_count", window_count, v.cnt);
					if (entry_replaced !== v.repl)
						report_mismatch("entry_replaced", entry_replaced, v.repl);
					if (v.act != prlt_pkg::ACT_CONTINUE)
						n_rejects++;
					if (v.repl)
						n_replaced++;
				end
			end
			if (cfg_valid && cfg_ready)
				drop_mode = cfg_data;
			if (in_valid && !in_stall)
				verdicts_q.push_back(rate_verdict(address_high, address_low,
					now_seconds, conn_limit));
			pending = verdicts_q.size();
		end
	end

endmodule

// ----- dv/tb_per_client_rate_limit_table.sv -----
// ---------------------------------------------------------------------------
// tb_per_client_rate_limit_table: testbench for the per-client rate limiter
// Drives directed and random connection requests from a pool of clients,
// including a cluster sharing one hash home, under both reject modes, with
// random output stalls and input gaps; checker predicts and compares results.
// ---------------------------------------------------------------------------
module tb_per_client_rate_limit_table;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int POOL_RANDOM = 40;
	localparam int CLUSTER     = 32;
	localparam int POOL_SIZE   = POOL_RANDOM + CLUSTER + 2;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [prlt_pkg::ADDR_W-1:0]   address_high = '0;
	logic [prlt_pkg::ADDR_W-1:0]   address_low = '0;
	logic [prlt_pkg::TIME_W-1:0]   now_seconds = '0;
	logic [prlt_pkg::LIMIT_W-1:0]  conn_limit = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [prlt_pkg::ACTION_W-1:0] action;
	logic [prlt_pkg::SUM_W-1:0]    window_count;
	logic                          entry_replaced;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic                          cfg_data = 1'b0;

	int errors, pending, n_rejects, n_replaced;
	int  cycles = 0;
	int  sent = 0;
	bit  calm = 1'b0;
	bit  hold_now = 1'b0;
	bit  in_low = 1'b1;
	bit [prlt_pkg::ADDR_W-1:0] pool_hi [POOL_SIZE];
	bit [prlt_pkg::ADDR_W-1:0] pool_lo [POOL_SIZE];
	bit [prlt_pkg::TIME_W-1:0] clock_s;

	always #2 clk = ~clk;

	per_client_rate_limit_table dut (.*);

	prlt_checker chk (.*);

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("per_client_rate_limit_table test failed");
			$finish;
		end
	end

	// result side stalls: random bursts plus one long hold-off
	always @(posedge clk) begin
		int burst, hold;
		if (hold_now && hold == 0 && burst >= 0) begin
			hold = 400;
			hold_now = 1'b0;
		end
		if (hold > 0) begin
			hold--;
			out_stall <= 1'b1;
		end else if (burst > 0) begin
			burst--;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			burst = int'($urandom_range(0, 3));
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// hash home of an address, used to build the colliding cluster
	function automatic bit [prlt_pkg::ENTRY_W-1:0] home_of(bit [prlt_pkg::ADDR_W-1:0] ah,
			bit [prlt_pkg::ADDR_W-1:0] al);
		bit [prlt_pkg::HASH_W-1:0] h;
		h = prlt_pkg::HASH_SEED;
		for (int k = 56; k >= 0; k -= 8)
			h = (h * 33) ^ prlt_pkg::HASH_W'(ah[k+:8]);
		for (int k = 56; k >= 0; k -= 8)
			h = (h * 33) ^ prlt_pkg::HASH_W'(al[k+:8]);
		return prlt_pkg::ENTRY_W'(h);
	endfunction

	function automatic bit [prlt_pkg::ADDR_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// offer one request and hold it until taken, then maybe idle
	task automatic send_req(bit [prlt_pkg::ADDR_W-1:0] ah, bit [prlt_pkg::ADDR_W-1:0] al,
			bit [prlt_pkg::TIME_W-1:0] now, bit [prlt_pkg::LIMIT_W-1:0] lim);
		address_high <= ah;
		address_low <= al;
		now_seconds <= now;
		conn_limit <= lim;
		in_valid <= 1'b1;
		in_low = 1'b0;
		do @(posedge clk); while (in_stall);
		sent++;
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			in_low = 1'b1;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// drain all results, then write the reject mode
	task automatic set_mode(bit drop);
		if (!in_low)
			in_valid <= 1'b0;
		in_low = 1'b1;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
		cfg_data <= drop;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// random requests, mostly from the client pool
	task automatic random_phase(int n);
		bit [prlt_pkg::ADDR_W-1:0] ah, al;
		bit [prlt_pkg::LIMIT_W-1:0] lim;
		int p, r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 85) begin
				p = (r < 35) ? POOL_RANDOM + $urandom_range(0, CLUSTER - 1)
					: $urandom_range(0, POOL_SIZE - 1);
				ah = pool_hi[p];
				al = pool_lo[p];
			end else begin
				ah = rand64();
				al = rand64();
			end
			r = $urandom_range(0, 99);
			if (r < 3)
				clock_s = $urandom;
			else if (r < 6)
				clock_s -= $urandom_range(1, 120);
			else if (r < 9)
				clock_s += $urandom_range(60, 600);
			else
				clock_s += $urandom_range(0, 3);
			r = $urandom_range(0, 99);
			if (r < 5)
				lim = '0;
			else if (r < 10)
				lim = prlt_pkg::LIMIT_W'($urandom);
			else if (r < 13)
				lim = '1;
			else
				lim = prlt_pkg::LIMIT_W'($urandom_range(1, 12));
			send_req(ah, al, clock_s, lim);
		end
	endtask

	initial begin
		bit [prlt_pkg::ENTRY_W-1:0] target;
		bit [prlt_pkg::ADDR_W-1:0] ah, al;
		int k;

		// client pool: random clients, a cluster on one home, all zeros, all ones
		for (int i = 0; i < POOL_RANDOM; i++) begin
			pool_hi[i] = rand64();
			pool_lo[i] = rand64();
		end
		target = prlt_pkg::ENTRY_W'($urandom);
		k = POOL_RANDOM;
		while (k < POOL_RANDOM + CLUSTER) begin
			ah = rand64();
			al = rand64();
			if (home_of(ah, al) == target) begin
				pool_hi[k] = ah;
				pool_lo[k] = al;
				k++;
			end
		end
		pool_hi[POOL_SIZE-2] = '0;
		pool_lo[POOL_SIZE-2] = '0;
		pool_hi[POOL_SIZE-1] = '1;
		pool_lo[POOL_SIZE-1] = '1;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero address, extremes, bypass, rejects, time going backwards
		send_req('0, '0, 32'd0, 16'd1);
		send_req('0, '0, 32'd1, 16'd1);
		send_req('1, '1, '1, '1);
		send_req('1, '1, '1, 16'd1);
		send_req(pool_hi[0], pool_lo[0], 32'd1000, '0);
		send_req(pool_hi[0], pool_lo[0], 32'd1000, 16'd2);
		send_req(pool_hi[0], pool_lo[0], 32'd1003, 16'd2);
		send_req(pool_hi[0], pool_lo[0], 32'd1010, 16'd2);
		send_req(pool_hi[0], pool_lo[0], 32'd900, 16'd2);
		send_req(pool_hi[0], pool_lo[0], 32'd1059, 16'd2);
		send_req(pool_hi[0], pool_lo[0], 32'd1200, 16'd2);
		for (int i = 0; i < 6; i++)
			send_req(pool_hi[POOL_RANDOM + i], pool_lo[POOL_RANDOM + i], 32'd2000, 16'd3);
		set_mode(1'b0);
		send_req(pool_hi[0], pool_lo[0], 32'd1201, 16'd1);
		send_req(pool_hi[0], pool_lo[0], 32'd1202, 16'd1);
		send_req('0, '0, 32'h8000_0000, 16'd1);

		// random phases, cycling the reject mode; long hold-off in the second
		clock_s = $urandom;
		set_mode(1'b1);
		random_phase(350);
		set_mode(1'b0);
		hold_now = 1'b1;
		random_phase(350);
		set_mode(1'b1);
		random_phase(350);
		set_mode(1'b0);
		calm = 1'b1;
		random_phase(350);

		if (!in_low)
			in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (120) @(posedge clk);
		$display("covered %0d requests over both reject modes: %0d rejected, %0d entries taken",
			sent, n_rejects, n_replaced);
		if (errors == 0)
			$display("per_client_rate_limit_table test passed");
		else
			$display("per_client_rate_limit_table test failed");
		$finish;
	end

endmodule

// ----- per_client_rate_limit_table.f -----
design/prlt_pkg.sv
design/prlt_ctrl.sv
design/prlt_dpath.sv
design/per_client_rate_limit_table.sv
dv/prlt_checker.sv
dv/tb_per_client_rate_limit_table.sv
